>>> hdl/vfc_pkg.sv
// Shared types and constants for the six-plane frustum cull test.
package vfc_pkg;

  localparam int PLANE_COUNT_DEF = 6;
  localparam int COORD_WIDTH_DEF = 24;
  localparam int NORMAL_WIDTH    = 16;
  localparam int NORMAL_FRAC     = 14;
  localparam int INDEX_WIDTH     = 3;
  localparam int ACTION_WIDTH    = 3;

  typedef enum logic [ACTION_WIDTH-1:0] {
    ACT_LOAD   = 3'd0,
    ACT_POINT  = 3'd1,
    ACT_SPHERE = 3'd2,
    ACT_BOX    = 3'd3,
    ACT_CUBE   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic busy;
    logic hit_valid;
    logic behind;
  } dot_stat_t;

endpackage

>>> hdl/view_frustum_cull_test.sv
// Frustum cull test top level: request control, plane ring and distance unit.
//
// Holds PLANE_COUNT planes in a ring of cells. A load request writes one cell
// (an index beyond the ring writes nothing) and answers 0; an unknown action
// also answers 0. A point, sphere, box or cube test rotates the ring once
// through a single three-stage distance unit, one plane per cycle. One
// request is in work at a time; a finished answer waits in the output
// register while the next request is taken. Answer 1 means not culled.
module view_frustum_cull_test
  import vfc_pkg::*;
#(
  parameter int PLANE_COUNT = PLANE_COUNT_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ACTION_WIDTH-1:0]        action_i,
  input  logic [INDEX_WIDTH-1:0]         plane_index_i,
  input  logic signed [COORD_WIDTH-1:0]  pos_x_i,
  input  logic signed [COORD_WIDTH-1:0]  pos_y_i,
  input  logic signed [COORD_WIDTH-1:0]  pos_z_i,
  input  logic [COORD_WIDTH-2:0]         extent_x_i,
  input  logic [COORD_WIDTH-2:0]         extent_y_i,
  input  logic [COORD_WIDTH-2:0]         extent_z_i,
  input  logic signed [NORMAL_WIDTH-1:0] normal_a_i,
  input  logic signed [NORMAL_WIDTH-1:0] normal_b_i,
  input  logic signed [NORMAL_WIDTH-1:0] normal_c_i,
  input  logic signed [COORD_WIDTH-1:0]  offset_d_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           inside_res_o
);

  localparam int CNT_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

  state_e                        state_q, state_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic                          flag_q, flag_d;
  logic                          out_valid_q, out_valid_d;
  logic                          inside_q, inside_d;

  action_e                       mode_q;
  logic signed [COORD_WIDTH-1:0] px_q, py_q, pz_q;
  logic [COORD_WIDTH-2:0]        ex_q, ey_q, ez_q;

  logic                          accept;
  logic                          is_test;
  logic                          is_cube;
  logic                          issue;
  logic                          out_free;
  logic                          cnt_last;
  cell_ctrl_t                    ctrl;
  dot_stat_t                     stat;

  logic signed [NORMAL_WIDTH-1:0] cell_a [PLANE_COUNT];
  logic signed [NORMAL_WIDTH-1:0] cell_b [PLANE_COUNT];
  logic signed [NORMAL_WIDTH-1:0] cell_c [PLANE_COUNT];
  logic signed [COORD_WIDTH-1:0]  cell_d [PLANE_COUNT];

  assign accept   = in_valid_i && !in_stall_o;
  assign is_test  = (action_i == ACT_POINT) || (action_i == ACT_SPHERE) ||
                    (action_i == ACT_BOX) || (action_i == ACT_CUBE);
  assign is_cube  = (action_i == ACT_CUBE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign cnt_last = (cnt_q == CNT_W'(PLANE_COUNT - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = is_test ? ST_RUN : ST_FINISH;
      end
      ST_RUN: begin
        if (cnt_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.busy) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall_o = 1'b1;
    issue      = 1'b0;
    ctrl.shift = 1'b0;
    ctrl.load  = 1'b0;
    cnt_d      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        ctrl.load  = in_valid_i && (action_i == ACT_LOAD);
      end
      ST_RUN: begin
        issue      = 1'b1;
        ctrl.shift = 1'b1;
        cnt_d      = cnt_q + CNT_W'(1);
      end
      ST_DRAIN: ;
      ST_FINISH: ;
      default: ;
    endcase
  end

  // Track the answer: clear on any plane that has the object behind it.
  always_comb begin
    flag_d = flag_q;
    if (accept) begin
      flag_d = is_test;
    end else if (stat.hit_valid && stat.behind) begin
      flag_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    inside_d    = inside_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if ((state_q == ST_FINISH) && out_free) begin
      out_valid_d = 1'b1;
      inside_d    = flag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the request; a cube uses its half size on all three axes.
  always_ff @(posedge clk_i) begin
    inside_q <= inside_d;
    if (accept) begin
      mode_q <= action_e'(action_i);
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      pz_q   <= pos_z_i;
      ex_q   <= extent_x_i;
      ey_q   <= is_cube ? extent_x_i : extent_y_i;
      ez_q   <= is_cube ? extent_x_i : extent_z_i;
    end
  end

  for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
    localparam int NEXT = (i + 1) % PLANE_COUNT;
    vfc_cell #(
      .COORD_WIDTH (COORD_WIDTH),
      .CELL_INDEX  (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .load_index_i (plane_index_i),
      .load_a_i     (normal_a_i),
      .load_b_i     (normal_b_i),
      .load_c_i     (normal_c_i),
      .load_d_i     (offset_d_i),
      .next_a_i     (cell_a[NEXT]),
      .next_b_i     (cell_b[NEXT]),
      .next_c_i     (cell_c[NEXT]),
      .next_d_i     (cell_d[NEXT]),
      .a_o          (cell_a[i]),
      .b_o          (cell_b[i]),
      .c_o          (cell_c[i]),
      .d_o          (cell_d[i])
    );
  end

  vfc_dot #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .mode_i  (mode_q),
    .pos_x_i (px_q),
    .pos_y_i (py_q),
    .pos_z_i (pz_q),
    .ext_x_i (ex_q),
    .ext_y_i (ey_q),
    .ext_z_i (ez_q),
    .a_i     (cell_a[0]),
    .b_i     (cell_b[0]),
    .c_i     (cell_c[0]),
    .d_i     (cell_d[0]),
    .stat_o  (stat)
  );

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

endmodule

>>> hdl/vfc_cell.sv
// One plane cell of the rotating plane ring.
module vfc_cell
  import vfc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int CELL_INDEX  = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cell_ctrl_t                    ctrl_i,
  input  logic [INDEX_WIDTH-1:0]        load_index_i,
  input  logic signed [NORMAL_WIDTH-1:0] load_a_i,
  input  logic signed [NORMAL_WIDTH-1:0] load_b_i,
  input  logic signed [NORMAL_WIDTH-1:0] load_c_i,
  input  logic signed [COORD_WIDTH-1:0]  load_d_i,
  input  logic signed [NORMAL_WIDTH-1:0] next_a_i,
  input  logic signed [NORMAL_WIDTH-1:0] next_b_i,
  input  logic signed [NORMAL_WIDTH-1:0] next_c_i,
  input  logic signed [COORD_WIDTH-1:0]  next_d_i,
  output logic signed [NORMAL_WIDTH-1:0] a_o,
  output logic signed [NORMAL_WIDTH-1:0] b_o,
  output logic signed [NORMAL_WIDTH-1:0] c_o,
  output logic signed [COORD_WIDTH-1:0]  d_o
);

  logic signed [NORMAL_WIDTH-1:0] a_q, a_d;
  logic signed [NORMAL_WIDTH-1:0] b_q, b_d;
  logic signed [NORMAL_WIDTH-1:0] c_q, c_d;
  logic signed [COORD_WIDTH-1:0]  d_q, d_d;
  logic                           hit;

  assign hit = ctrl_i.load && (load_index_i == INDEX_WIDTH'(CELL_INDEX));

  // Load and shift never coincide: loads happen only between tests.
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    c_d = c_q;
    d_d = d_q;
    if (hit) begin
      a_d = load_a_i;
      b_d = load_b_i;
      c_d = load_c_i;
      d_d = load_d_i;
    end else if (ctrl_i.shift) begin
      a_d = next_a_i;
      b_d = next_b_i;
      c_d = next_c_i;
      d_d = next_d_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
      c_q <= '0;
      d_q <= '0;
    end else begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= c_d;
      d_q <= d_d;
    end
  end

  assign a_o = a_q;
  assign b_o = b_q;
  assign c_o = c_q;
  assign d_o = d_q;

endmodule

>>> hdl/vfc_dot.sv
// Three-stage signed plane distance unit: vertex pick, products, sum and sign.
module vfc_dot
  import vfc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           issue_i,
  input  action_e                        mode_i,
  input  logic signed [COORD_WIDTH-1:0]  pos_x_i,
  input  logic signed [COORD_WIDTH-1:0]  pos_y_i,
  input  logic signed [COORD_WIDTH-1:0]  pos_z_i,
  input  logic [COORD_WIDTH-2:0]         ext_x_i,
  input  logic [COORD_WIDTH-2:0]         ext_y_i,
  input  logic [COORD_WIDTH-2:0]         ext_z_i,
  input  logic signed [NORMAL_WIDTH-1:0] a_i,
  input  logic signed [NORMAL_WIDTH-1:0] b_i,
  input  logic signed [NORMAL_WIDTH-1:0] c_i,
  input  logic signed [COORD_WIDTH-1:0]  d_i,
  output dot_stat_t                      stat_o
);

  localparam int VW = COORD_WIDTH + 1;
  localparam int PW = VW + NORMAL_WIDTH;
  localparam int SW = PW + 2;

  logic                           box;
  logic signed [VW-1:0]           px_e, py_e, pz_e;
  logic signed [VW-1:0]           ex_e, ey_e, ez_e;
  logic signed [VW-1:0]           vx_d, vy_d, vz_d, od_d;
  logic signed [VW-1:0]           vx_q, vy_q, vz_q, od_q;
  logic signed [NORMAL_WIDTH-1:0] a_q, b_q, c_q;
  logic                           v_valid_q;

  logic signed [PW-1:0]           pa_d, pb_d, pc_d;
  logic signed [PW-1:0]           pa_q, pb_q, pc_q;
  logic signed [VW-1:0]           om_q;
  logic                           m_valid_q;
  logic signed [SW-1:0]           sum;

  assign box  = (mode_i == ACT_BOX) || (mode_i == ACT_CUBE);
  assign px_e = VW'(pos_x_i);
  assign py_e = VW'(pos_y_i);
  assign pz_e = VW'(pos_z_i);
  assign ex_e = {2'b00, ext_x_i};
  assign ey_e = {2'b00, ext_y_i};
  assign ez_e = {2'b00, ext_z_i};

  // Pick the positive vertex from the normal signs for boxes and cubes.
  always_comb begin
    vx_d = px_e;
    vy_d = py_e;
    vz_d = pz_e;
    if (box) begin
      vx_d = a_i[NORMAL_WIDTH-1] ? px_e - ex_e : px_e + ex_e;
      vy_d = b_i[NORMAL_WIDTH-1] ? py_e - ey_e : py_e + ey_e;
      vz_d = c_i[NORMAL_WIDTH-1] ? pz_e - ez_e : pz_e + ez_e;
    end
    // Fold the sphere radius into the offset.
    od_d = VW'(d_i) + ((mode_i == ACT_SPHERE) ? ex_e : VW'(0));
  end

  assign pa_d = PW'(a_q) * PW'(vx_q);
  assign pb_d = PW'(b_q) * PW'(vy_q);
  assign pc_d = PW'(c_q) * PW'(vz_q);

  assign sum = SW'(pa_q) + SW'(pb_q) + SW'(pc_q) + (SW'(om_q) <<< NORMAL_FRAC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      v_valid_q <= issue_i;
      m_valid_q <= v_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    vx_q <= vx_d;
    vy_q <= vy_d;
    vz_q <= vz_d;
    od_q <= od_d;
    a_q  <= a_i;
    b_q  <= b_i;
    c_q  <= c_i;
    pa_q <= pa_d;
    pb_q <= pb_d;
    pc_q <= pc_d;
    om_q <= od_q;
  end

  assign stat_o.busy      = v_valid_q || m_valid_q;
  assign stat_o.hit_valid = m_valid_q;
  assign stat_o.behind    = sum[SW-1];

endmodule

>>> test/view_frustum_cull_checker.sv
// Checker for the frustum cull test: tracks the stored planes, predicts each answer and compares.
`timescale 1ns / 100ps

module view_frustum_cull_checker
  import vfc_pkg::*;
(
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [ACTION_WIDTH-1:0]           action_i,
  input  logic [INDEX_WIDTH-1:0]            plane_index_i,
  input  logic signed [COORD_WIDTH_DEF-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH_DEF-1:0] pos_y_i,
  input  logic signed [COORD_WIDTH_DEF-1:0] pos_z_i,
  input  logic [COORD_WIDTH_DEF-2:0]        extent_x_i,
  input  logic [COORD_WIDTH_DEF-2:0]        extent_y_i,
  input  logic [COORD_WIDTH_DEF-2:0]        extent_z_i,
  input  logic signed [NORMAL_WIDTH-1:0]    normal_a_i,
  input  logic signed [NORMAL_WIDTH-1:0]    normal_b_i,
  input  logic signed [NORMAL_WIDTH-1:0]    normal_c_i,
  input  logic signed [COORD_WIDTH_DEF-1:0] offset_d_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic                              inside_res_i,
  output int                                fail_cnt_o,
  output int                                pending_o,
  output int                                checked_o,
  output int                                visible_o
);

  localparam int MAX_REPORTS = 10;

  logic signed [NORMAL_WIDTH-1:0]    nrm_a [PLANE_COUNT_DEF];
  logic signed [NORMAL_WIDTH-1:0]    nrm_b [PLANE_COUNT_DEF];
  logic signed [NORMAL_WIDTH-1:0]    nrm_c [PLANE_COUNT_DEF];
  logic signed [COORD_WIDTH_DEF-1:0] ofs_d [PLANE_COUNT_DEF];

  logic verdict_q [$];
  logic want;
  int   fails;
  int   checked;
  int   visible;

  // Signed distance in Q.22: normals are Q1.14, coordinates and offset Q15.8.
  function automatic longint plane_distance(int p, longint x, longint y, longint z);
    return longint'(nrm_a[p]) * x + longint'(nrm_b[p]) * y + longint'(nrm_c[p]) * z
         + (longint'(ofs_d[p]) <<< NORMAL_FRAC);
  endfunction

  function automatic logic cull_verdict(logic [ACTION_WIDTH-1:0] act, longint px,
                                        longint py, longint pz, longint ex,
                                        longint ey, longint ez);
    logic   visible_now;
    longint vx;
    longint vy;
    longint vz;
    longint reach;
    if (act != ACT_POINT && act != ACT_SPHERE && act != ACT_BOX && act != ACT_CUBE)
      return 1'b0;
    if (act == ACT_CUBE) begin
      ey = ex;
      ez = ex;
    end
    visible_now = 1'b1;
    for (int p = 0; p < PLANE_COUNT_DEF; p++) begin
      if (act == ACT_POINT || act == ACT_SPHERE) begin
        reach = plane_distance(p, px, py, pz);
        // behind by more than the radius: move the threshold to zero
        if (act == ACT_SPHERE)
          reach = reach + (ex <<< NORMAL_FRAC);
      end else begin
        // take the corner furthest along the normal
        vx = nrm_a[p][NORMAL_WIDTH-1] ? px - ex : px + ex;
        vy = nrm_b[p][NORMAL_WIDTH-1] ? py - ey : py + ey;
        vz = nrm_c[p][NORMAL_WIDTH-1] ? pz - ez : pz + ez;
        reach = plane_distance(p, vx, vy, vz);
      end
      if (reach < 0)
        visible_now = 1'b0;
    end
    return visible_now;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PLANE_COUNT_DEF; p++) begin
        nrm_a[p] = '0;
        nrm_b[p] = '0;
        nrm_c[p] = '0;
        ofs_d[p] = '0;
      end
      verdict_q.delete();
      fails   = 0;
      checked = 0;
      visible = 0;
    end else begin
      // answers leave before the request of the same edge is queued
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (inside_res_i === 1'b1)
          visible++;
        if (verdict_q.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: answer %0d (inside_res %b) with no request waiting",
                     $time, checked, inside_res_i);
        end else begin
          want = verdict_q.pop_front();
          if (inside_res_i !== want) begin
            fails++;
            if (fails <= MAX_REPORTS)
              $display("%0t: answer %0d inside_res expected %b, got %b",
                       $time, checked, want, inside_res_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (action_i == ACT_LOAD) begin
          if (plane_index_i < PLANE_COUNT_DEF) begin
            nrm_a[plane_index_i] = normal_a_i;
            nrm_b[plane_index_i] = normal_b_i;
            nrm_c[plane_index_i] = normal_c_i;
            ofs_d[plane_index_i] = offset_d_i;
          end
          verdict_q.push_back(1'b0);
        end else begin
          verdict_q.push_back(cull_verdict(action_i, longint'(pos_x_i),
                                           longint'(pos_y_i), longint'(pos_z_i),
                                           longint'(extent_x_i), longint'(extent_y_i),
                                           longint'(extent_z_i)));
        end
      end
    end
    fail_cnt_o <= fails;
    pending_o  <= verdict_q.size();
    checked_o  <= checked;
    visible_o  <= visible;
  end

endmodule

>>> test/tb_view_frustum_cull_test.sv
// Testbench top for the frustum cull test: clock, reset, requests, answer stalls and verdict.
`timescale 1ns / 100ps

module tb_view_frustum_cull_test;
  import vfc_pkg::*;

  localparam int RANDOM_ITEMS = 1250;
  localparam int DRAIN_CYCLES = 16;
  localparam int LIMIT_CYCLES = 400000;

  localparam logic [INDEX_WIDTH-1:0] PLANE_NEAR   = 3'd0;
  localparam logic [INDEX_WIDTH-1:0] PLANE_FAR    = 3'd1;
  localparam logic [INDEX_WIDTH-1:0] PLANE_BOTTOM = 3'd5;
  localparam logic [INDEX_WIDTH-1:0] INDEX_MAX    = 3'd7;

  localparam logic [ACTION_WIDTH-1:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [ACTION_WIDTH-1:0] ACT_UNUSED_HI = 3'd7;

  localparam logic [23:0] C_MAX = 24'h7FFFFF;
  localparam logic [23:0] C_MIN = 24'h800000;
  localparam logic [22:0] E_MAX = 23'h7FFFFF;
  localparam logic [15:0] N_MAX = 16'h7FFF;
  localparam logic [15:0] N_MIN = 16'h8000;
  localparam logic [15:0] N_ONE = 16'h4000;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic [ACTION_WIDTH-1:0]           action_i;
  logic [INDEX_WIDTH-1:0]            plane_index_i;
  logic signed [COORD_WIDTH_DEF-1:0] pos_x_i;
  logic signed [COORD_WIDTH_DEF-1:0] pos_y_i;
  logic signed [COORD_WIDTH_DEF-1:0] pos_z_i;
  logic [COORD_WIDTH_DEF-2:0]        extent_x_i;
  logic [COORD_WIDTH_DEF-2:0]        extent_y_i;
  logic [COORD_WIDTH_DEF-2:0]        extent_z_i;
  logic signed [NORMAL_WIDTH-1:0]    normal_a_i;
  logic signed [NORMAL_WIDTH-1:0]    normal_b_i;
  logic signed [NORMAL_WIDTH-1:0]    normal_c_i;
  logic signed [COORD_WIDTH_DEF-1:0] offset_d_i;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic                              inside_res_o;

  int   fail_cnt;
  int   pending_cnt;
  int   checked_cnt;
  int   visible_cnt;
  int   act_cnt [8];
  int   sent_cnt;
  int   cycle_cnt;
  int   stall_left;
  int   stall_draw;
  logic calm;

  view_frustum_cull_test i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .plane_index_i (plane_index_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .extent_x_i    (extent_x_i),
    .extent_y_i    (extent_y_i),
    .extent_z_i    (extent_z_i),
    .normal_a_i    (normal_a_i),
    .normal_b_i    (normal_b_i),
    .normal_c_i    (normal_c_i),
    .offset_d_i    (offset_d_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .inside_res_o  (inside_res_o)
  );

  view_frustum_cull_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .action_i      (action_i),
    .plane_index_i (plane_index_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .extent_x_i    (extent_x_i),
    .extent_y_i    (extent_y_i),
    .extent_z_i    (extent_z_i),
    .normal_a_i    (normal_a_i),
    .normal_b_i    (normal_b_i),
    .normal_c_i    (normal_c_i),
    .offset_d_i    (offset_d_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .inside_res_i  (inside_res_o),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending_cnt),
    .checked_o     (checked_cnt),
    .visible_o     (visible_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("timed out after %0d cycles with %0d answers outstanding",
               cycle_cnt, pending_cnt);
      $display("FAIL");
      $finish;
    end
  end

  // Answer side: hold stall for a drawn number of cycles after every answer.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      stall_draw = calm ? 0 : $urandom_range(0, 14);
      stall_left  <= stall_draw;
      out_stall_i <= (stall_draw != 0);
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= (stall_left > 1);
    end
  end

  // Value sign-extended from a random width of 1 to maxw bits.
  function automatic logic [31:0] rand_signed(int maxw);
    logic signed [31:0] r;
    int                 sh;
    sh = 32 - $urandom_range(1, maxw);
    r  = $urandom;
    r  = r <<< sh;
    return r >>> sh;
  endfunction

  function automatic logic [22:0] rand_extent();
    int w;
    w = $urandom_range(0, 23);
    return 23'($urandom & ((32'd1 << w) - 32'd1));
  endfunction

  task automatic send_request(logic [ACTION_WIDTH-1:0] act, logic [INDEX_WIDTH-1:0] idx,
                              logic [23:0] px, logic [23:0] py, logic [23:0] pz,
                              logic [22:0] ex, logic [22:0] ey, logic [22:0] ez,
                              logic [15:0] na, logic [15:0] nb, logic [15:0] nc,
                              logic [23:0] od);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    plane_index_i <= idx;
    pos_x_i       <= px;
    pos_y_i       <= py;
    pos_z_i       <= pz;
    extent_x_i    <= ex;
    extent_y_i    <= ey;
    extent_z_i    <= ez;
    normal_a_i    <= na;
    normal_b_i    <= nb;
    normal_c_i    <= nc;
    offset_d_i    <= od;
    do @(posedge clk_i); while (in_stall_o);
    sent_cnt++;
    act_cnt[act]++;
  endtask

  // Offsets lean large and positive so that a fair share of objects survive.
  task automatic send_random_load(logic [INDEX_WIDTH-1:0] idx);
    logic [23:0] od;
    if ($urandom_range(0, 3) != 0)
      od = 24'($urandom_range(32'd1 << 20, (32'd1 << 23) - 1));
    else
      od = 24'(rand_signed(24));
    send_request(ACT_LOAD, idx, 24'(rand_signed(24)), 24'(rand_signed(24)),
                 24'(rand_signed(24)), rand_extent(), rand_extent(), rand_extent(),
                 16'(rand_signed(16)), 16'(rand_signed(16)), 16'(rand_signed(16)), od);
  endtask

  // Hold requests until every answer is in, then let the block settle.
  task automatic drain_answers();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int pick;
    int reload_left;
    int other_cnt;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    action_i      = ACT_LOAD;
    plane_index_i = '0;
    pos_x_i       = '0;
    pos_y_i       = '0;
    pos_z_i       = '0;
    extent_x_i    = '0;
    extent_y_i    = '0;
    extent_z_i    = '0;
    normal_a_i    = '0;
    normal_b_i    = '0;
    normal_c_i    = '0;
    offset_d_i    = '0;
    calm          = 1'b0;
    sent_cnt      = 0;
    cycle_cnt     = 0;
    reload_left   = 0;
    other_cnt     = 0;
    foreach (act_cnt[a]) act_cnt[a] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // planes still clear: everything is visible
    send_request(ACT_POINT, PLANE_NEAR, C_MIN, C_MAX, '0, '0, '0, '0, '0, '0, '0, '0);
    send_request(ACT_SPHERE, PLANE_NEAR, C_MAX, C_MIN, C_MAX, E_MAX, '0, '0,
                 '0, '0, '0, '0);
    send_request(ACT_BOX, PLANE_NEAR, C_MIN, C_MIN, C_MIN, E_MAX, E_MAX, E_MAX,
                 '0, '0, '0, '0);
    send_request(ACT_CUBE, PLANE_NEAR, C_MAX, C_MAX, C_MAX, '0, E_MAX, E_MAX,
                 '0, '0, '0, '0);
    // near plane keeps x >= 0; indexes past the ring must write nothing
    send_request(ACT_LOAD, PLANE_NEAR, '0, '0, '0, '0, '0, '0, N_ONE, '0, '0, '0);
    send_request(ACT_LOAD, INDEX_WIDTH'(PLANE_COUNT_DEF), '1, '1, '1, E_MAX, E_MAX, E_MAX,
                 N_MIN, N_MIN, N_MIN, C_MIN);
    send_request(ACT_LOAD, INDEX_MAX, '1, '1, '1, E_MAX, E_MAX, E_MAX,
                 N_MIN, N_MIN, N_MIN, C_MIN);
    send_request(ACT_POINT, PLANE_NEAR, '1, '0, '0, '0, '0, '0, '0, '0, '0, '0);
    send_request(ACT_POINT, PLANE_NEAR, '0, C_MIN, C_MAX, '0, '0, '0, '0, '0, '0, '0);
    // sphere and box right on the plane, then one step behind it
    send_request(ACT_SPHERE, PLANE_NEAR, 24'hFFFF00, '0, '0, 23'd256, '0, '0,
                 '0, '0, '0, '0);
    send_request(ACT_SPHERE, PLANE_NEAR, 24'hFFFEFF, '0, '0, 23'd256, '0, '0,
                 '0, '0, '0, '0);
    send_request(ACT_BOX, PLANE_NEAR, 24'hFFFF00, '0, '0, 23'd256, '0, '0,
                 '0, '0, '0, '0);
    send_request(ACT_BOX, PLANE_NEAR, 24'hFFFEFF, '0, '0, 23'd256, E_MAX, E_MAX,
                 '0, '0, '0, '0);
    send_request(ACT_CUBE, PLANE_NEAR, 24'hFFFEFF, '0, '0, 23'd256, '0, '0,
                 '0, '0, '0, '0);
    for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++)
      send_request(ACTION_WIDTH'(a), INDEX_MAX, '1, '1, '1, E_MAX, E_MAX, E_MAX,
                   N_MIN, N_MIN, N_MIN, '1);
    send_request(ACT_LOAD, PLANE_FAR, '0, '0, '0, '0, '0, '0, N_MIN, N_MAX, '1, C_MAX);
    send_request(ACT_LOAD, PLANE_BOTTOM, '0, '0, '0, '0, '0, '0,
                 N_MAX, N_MIN, N_MAX, C_MIN);
    send_request(ACT_POINT, PLANE_NEAR, C_MAX, C_MIN, C_MAX, '0, '0, '0, '0, '0, '0, '0);
    send_request(ACT_SPHERE, PLANE_NEAR, C_MIN, C_MAX, C_MIN, E_MAX, '0, '0,
                 '0, '0, '0, '0);
    send_request(ACT_BOX, PLANE_NEAR, C_MAX, C_MAX, C_MAX, E_MAX, E_MAX, E_MAX,
                 '0, '0, '0, '0);
    send_request(ACT_CUBE, PLANE_NEAR, C_MIN, C_MIN, C_MIN, E_MAX, '0, '0,
                 '0, '0, '0, '0);
    drain_answers();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0)
        calm <= ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2)
        drain_answers();
      if (reload_left == 0 && $urandom_range(0, 39) == 0)
        reload_left = PLANE_COUNT_DEF;
      if (reload_left != 0) begin
        // fresh frustum: walk the ring from near to bottom
        send_random_load(INDEX_WIDTH'(PLANE_COUNT_DEF - reload_left));
        reload_left--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 6)
          send_random_load(INDEX_WIDTH'($urandom_range(0, INDEX_MAX)));
        else
          send_request(ACTION_WIDTH'(pick < 8 ? $urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)
                                              : $urandom_range(ACT_POINT, ACT_CUBE)),
                       INDEX_WIDTH'($urandom_range(0, INDEX_MAX)),
                       24'(rand_signed(24)), 24'(rand_signed(24)), 24'(rand_signed(24)),
                       rand_extent(), rand_extent(), rand_extent(),
                       16'(rand_signed(16)), 16'(rand_signed(16)), 16'(rand_signed(16)),
                       24'(rand_signed(24)));
      end
    end
    drain_answers();

    for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++)
      other_cnt += act_cnt[a];
    $display("sent %0d requests: %0d loads, %0d point, %0d sphere, %0d box, %0d cube, %0d other",
             sent_cnt, act_cnt[ACT_LOAD], act_cnt[ACT_POINT], act_cnt[ACT_SPHERE],
             act_cnt[ACT_BOX], act_cnt[ACT_CUBE], other_cnt);
    $display("checked %0d answers, %0d not culled, %0d mismatches in %0d cycles",
             checked_cnt, visible_cnt, fail_cnt, cycle_cnt);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/vfc_pkg.sv
hdl/vfc_cell.sv
hdl/vfc_dot.sv
hdl/view_frustum_cull_test.sv
test/view_frustum_cull_checker.sv
test/tb_view_frustum_cull_test.sv
